// File: design/vbdd_pkg.sv
// ----------------------------------------------------------------------------
// vbdd_pkg: shared types and constants of the vertical byte delta decoder
// Holds the parser phase encoding, register map and the structs that pass
// configuration and write commands between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package vbdd_pkg;

	// Widths fixed by the stream format.
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned STRIDE_W  = 16;
	localparam int unsigned COL_W     = 16;
	localparam int unsigned LIT_W     = 7;
	localparam int unsigned OUT_OFF_W = 24;
	// Product of the row stride and one byte of rows.
	localparam int unsigned PROD_W    = STRIDE_W + BYTE_W;

	// Configuration port.
	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 32;
	localparam logic [1:0]  REG_ROW_STRIDE   = 2'd0;
	localparam logic [1:0]  REG_COLUMN_COUNT = 2'd1;
	localparam logic [1:0]  REG_XOR_MODE     = 2'd2;

	localparam logic [STRIDE_W-1:0] RST_ROW_STRIDE   = 16'd40;
	localparam logic [COL_W-1:0]    RST_COLUMN_COUNT = 16'd40;
	localparam logic                RST_XOR_MODE     = 1'b1;

	// Op byte layout: the top bit marks a literal op, the rest is its length.
	localparam int unsigned OP_LITERAL_BIT = 7;

	typedef enum logic [2:0] {
		PH_OPCOUNT  = 3'd0,
		PH_OP       = 3'd1,
		PH_LITERAL  = 3'd2,
		PH_RUNCOUNT = 3'd3,
		PH_RUNVALUE = 3'd4
	} phase_t;

	typedef struct packed {
		logic [STRIDE_W-1:0] row_stride;
		logic [COL_W-1:0]    column_count;
		logic                xor_mode;
	} cfg_t;

	typedef struct packed {
		logic                 valid;
		logic [OUT_OFF_W-1:0] write_offset;
		logic [BYTE_W-1:0]    write_value;
		logic [BYTE_W-1:0]    repeat_count;
		logic                 write_xor;
		logic                 end_of_frame;
	} res_t;

endpackage

`default_nettype wire

// File: design/vbdd_cfg.sv
// ----------------------------------------------------------------------------
// vbdd_cfg: configuration registers
// Holds row stride, column count and XOR mode behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module vbdd_cfg
	import vbdd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output      logic [APB_DATA_W-1:0] prdata,
	output      logic                  pready,
	output      cfg_t                  cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	// Addresses are word aligned; an address beyond the map writes nothing.
	assign wr_en   = psel && penable && pwrite && (paddr[1:0] == 2'b00);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_stride   <= RST_ROW_STRIDE;
			cfg_q.column_count <= RST_COLUMN_COUNT;
			cfg_q.xor_mode     <= RST_XOR_MODE;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ROW_STRIDE:   cfg_q.row_stride   <= pwdata[STRIDE_W-1:0];
				REG_COLUMN_COUNT: cfg_q.column_count <= pwdata[COL_W-1:0];
				REG_XOR_MODE:     cfg_q.xor_mode     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (reg_idx)
				REG_ROW_STRIDE:   prdata = APB_DATA_W'(cfg_q.row_stride);
				REG_COLUMN_COUNT: prdata = APB_DATA_W'(cfg_q.column_count);
				REG_XOR_MODE:     prdata = APB_DATA_W'(cfg_q.xor_mode);
				default:          prdata = '0;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: design/vbdd_parse.sv
// ----------------------------------------------------------------------------
// vbdd_parse: delta stream parser
// Holds the parse state and turns one registered delta byte per step into
// at most one write command.
// ----------------------------------------------------------------------------
`default_nettype none

module vbdd_parse
	import vbdd_pkg::*;
#(
	parameter int unsigned OFFSET_BITS = 24
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [BYTE_W-1:0] delta,
	input  wire logic [PROD_W-1:0] prod,
	input  wire cfg_t              cfg,
	output      res_t              res
);

	phase_t                 phase_q, phase_n;
	logic [COL_W-1:0]       col_q, col_n;
	logic [BYTE_W-1:0]      ops_q, ops_n;
	logic [LIT_W-1:0]       lit_q, lit_n;
	logic [BYTE_W-1:0]      pend_cnt_q, pend_cnt_n;
	logic [PROD_W-1:0]      run_prod;
	logic [OFFSET_BITS-1:0] offset_q, offset_n;
	logic [OFFSET_BITS-1:0] mark_off;
	logic [OFFSET_BITS-1:0] prod_o;
	logic [OFFSET_BITS-1:0] stride_o;
	logic                   wr;
	logic [BYTE_W-1:0]      wr_cnt;
	logic                   done;
	logic                   last_col;
	logic                   eof;

	assign prod_o   = OFFSET_BITS'(prod);
	assign stride_o = OFFSET_BITS'(cfg.row_stride);
	// The run step uses the stride in force when the run value arrives.
	assign run_prod = PROD_W'(cfg.row_stride) * PROD_W'(pend_cnt_q);
	// A column count of zero behaves as one column.
	assign last_col = ({1'b0, col_q} + 17'd1) >= {1'b0, cfg.column_count};

	always_comb begin
		phase_n     = phase_q;
		col_n       = col_q;
		ops_n       = ops_q;
		lit_n       = lit_q;
		pend_cnt_n  = pend_cnt_q;
		offset_n    = offset_q;
		wr          = 1'b0;
		wr_cnt      = '0;
		done        = 1'b0;
		eof         = 1'b0;

		unique case (phase_q)
			PH_OPCOUNT: begin
				ops_n = delta;
				done  = 1'b1;
			end
			PH_OP: begin
				ops_n = ops_q - 8'd1;
				if (delta == '0) begin
					phase_n = PH_RUNCOUNT;
				end else if (!delta[OP_LITERAL_BIT]) begin
					offset_n = offset_q + prod_o;
					done     = 1'b1;
				end else begin
					lit_n = delta[LIT_W-1:0];
					if (lit_n == '0) begin
						done = 1'b1;
					end else begin
						phase_n = PH_LITERAL;
					end
				end
			end
			PH_LITERAL: begin
				wr       = 1'b1;
				wr_cnt   = 8'd1;
				offset_n = offset_q + stride_o;
				lit_n    = lit_q - 7'd1;
				done     = (lit_n == '0);
			end
			PH_RUNCOUNT: begin
				pend_cnt_n  = delta;
				phase_n     = PH_RUNVALUE;
			end
			default: begin
				if (pend_cnt_q != '0) begin
					wr       = 1'b1;
					wr_cnt   = pend_cnt_q;
					offset_n = offset_q + OFFSET_BITS'(run_prod);
				end
				done = 1'b1;
			end
		endcase

		// A marker reports the offset reached before the frame wraps round.
		mark_off = offset_n;

		if (done) begin
			if (ops_n != '0) begin
				phase_n = PH_OP;
			end else begin
				phase_n = PH_OPCOUNT;
				if (last_col) begin
					col_n    = '0;
					offset_n = '0;
					eof      = 1'b1;
				end else begin
					col_n    = col_q + 16'd1;
					offset_n = OFFSET_BITS'(col_n);
				end
			end
		end

		res.valid        = wr || eof;
		res.write_offset = wr ? OUT_OFF_W'(offset_q) : OUT_OFF_W'(mark_off);
		res.write_value  = wr ? delta : '0;
		res.repeat_count = wr_cnt;
		res.write_xor    = cfg.xor_mode;
		res.end_of_frame = eof;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OPCOUNT;
			col_q       <= '0;
			ops_q       <= '0;
			lit_q       <= '0;
			pend_cnt_q  <= '0;
			offset_q    <= '0;
		end else if (step) begin
			phase_q     <= phase_n;
			col_q       <= col_n;
			ops_q       <= ops_n;
			lit_q       <= lit_n;
			pend_cnt_q  <= pend_cnt_n;
			offset_q    <= offset_n;
		end
	end

endmodule

`default_nettype wire

// File: design/vertical_byte_delta_decoder_core.sv
// ----------------------------------------------------------------------------
// vertical_byte_delta_decoder_core: vertical byte-run delta decoder
// Parses a column-ordered delta stream for one bitplane into write commands.
// ----------------------------------------------------------------------------
// The decoder takes one delta byte per clock cycle on the slave stream while
// the master side keeps taking results, and produces at most one write command
// per byte on the master stream. Each byte passes through the input register,
// where the row stride is multiplied by the byte, and then the result register,
// behind the offset adder in the parser (for a run value the parser also
// multiplies the row stride by the stored run count). Sustained throughput
// is one word per cycle as long as the master side keeps taking results;
// when it stalls, the input register holds one byte and the slave side
// stalls in turn. Each command asks for repeat_count writes of write_value
// starting at write_offset and stepping by the row stride, either replacing
// the plane byte or XORing into it as the write_xor flag says. The command
// that completes the last column carries tlast; if that byte writes nothing,
// the command is a marker with a repeat count of zero. Configuration
// registers should only be written while no words are in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module vertical_byte_delta_decoder_core
	import vbdd_pkg::*;
#(
	parameter int unsigned OFFSET_BITS = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Configuration port.
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output      logic [APB_DATA_W-1:0] prdata,
	output      logic                  pready,
	// Delta byte stream.
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	input  wire logic [7:0]            s_tdata,   // [7:0] delta_byte
	// Write command stream.
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	output      logic [39:0]           m_tdata,   // [23:0] write_offset,
	                                              // [31:24] write_value,
	                                              // [39:32] repeat_count
	output      logic                  m_tlast,   // end_of_frame
	output      logic                  m_tuser    // [0] write_xor
);

	cfg_t              cfg;
	res_t              res;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [PROD_W-1:0] prod_s1;
	logic              out_free;
	logic              s1_fire;
	logic              s_fire;
	logic              out_valid_q;
	res_t              out_q;

	vbdd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The result register is free when it is empty or being emptied now.
	assign out_free = !out_valid_q || m_tready;
	// The byte in the input register is parsed once the result side can
	// take whatever it produces.
	assign s1_fire  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign s_fire   = s_tvalid && s_tready;

	// Input register. The stride product is formed here so that the parser
	// only has to add it to the running offset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			byte_s1 <= s_tdata;
			prod_s1 <= PROD_W'(cfg.row_stride) * PROD_W'(s_tdata);
		end
	end

	vbdd_parse #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s1_fire),
		.delta  (byte_s1),
		.prod   (prod_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= res.valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && res.valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.repeat_count, out_q.write_value, out_q.write_offset};
	assign m_tlast  = out_q.end_of_frame;
	assign m_tuser  = out_q.write_xor;

endmodule

`default_nettype wire

// File: sim/tb_vertical_byte_delta_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertical_byte_delta_decoder_core: stream testbench of the delta decoder
// Streams delta bytes into the decoder, predicts every write command from its
// own copy of the parser state and checks the command stream word by word.
// ----------------------------------------------------------------------------

module tb_vertical_byte_delta_decoder_core;
	import vbdd_pkg::*;

	localparam int OFFSET_W     = 24;
	localparam int SETTLE_TICKS = 4;
	localparam int DRAIN_LIMIT  = 200000;

	// One write command as it leaves the decoder.
	typedef struct packed {
		logic [23:0] offset;
		logic [7:0]  value;
		logic [7:0]  count;
		logic        xr;
		logic        eof;
	} write_cmd_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel, penable, pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid, s_tready;
	logic [7:0]            s_tdata;   // [7:0] delta_byte
	logic                  m_tvalid, m_tready;
	logic [39:0]           m_tdata;   // [23:0] write_offset, [31:24] write_value,
	                                  // [39:32] repeat_count
	logic                  m_tlast;   // end_of_frame
	logic                  m_tuser;   // [0] write_xor

	vertical_byte_delta_decoder_core #(.OFFSET_BITS(OFFSET_W)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	always #4 clk = ~clk;

	// Register copies, kept in step with every write on the configuration port.
	logic [15:0] stride_cfg;
	logic [15:0] cols_cfg;
	logic        xor_cfg;

	// Parser state of the prediction.
	phase_t              parse_ph;
	logic [15:0]         col_idx;
	logic [7:0]          ops_rem;
	logic [6:0]          lit_rem;
	logic [7:0]          run_len;
	logic [OFFSET_W-1:0] cur_off;

	write_cmd_t pending_writes[$];
	int         write_mismatches = 0;
	int         words_sent = 0;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;

	function automatic void step_rows(input logic [7:0] rows);
		cur_off = cur_off + OFFSET_W'(32'(stride_cfg) * 32'(rows));
	endfunction

	// Closes an operation; returns 1 when that completes the frame.
	function automatic logic close_op();
		logic frame_done;
		frame_done = 1'b0;
		if (ops_rem != 8'd0) begin
			parse_ph = PH_OP;
		end else begin
			parse_ph = PH_OPCOUNT;
			// A column at or past the last one ends the frame; a count of zero
			// therefore acts as a single column.
			if ({1'b0, col_idx} + 17'd1 >= {1'b0, cols_cfg}) begin
				col_idx    = 16'd0;
				frame_done = 1'b1;
			end else begin
				col_idx = col_idx + 16'd1;
				cur_off = OFFSET_W'(col_idx);
			end
		end
		return frame_done;
	endfunction

	function automatic void decode_delta_byte(input logic [7:0] b);
		logic                wr;
		logic                op_done;
		logic                eof;
		logic [OFFSET_W-1:0] off_after;
		write_cmd_t          cmd;
		wr      = 1'b0;
		op_done = 1'b0;
		eof     = 1'b0;
		cmd     = '0;
		case (parse_ph)
			PH_OPCOUNT: begin
				ops_rem = b;
				op_done = 1'b1;
			end
			PH_OP: begin
				ops_rem = ops_rem - 8'd1;
				if (b == 8'd0) begin
					parse_ph = PH_RUNCOUNT;
				end else if (!b[OP_LITERAL_BIT]) begin
					step_rows(b);
					op_done = 1'b1;
				end else begin
					lit_rem = b[6:0];
					if (lit_rem == 7'd0)
						op_done = 1'b1;
					else
						parse_ph = PH_LITERAL;
				end
			end
			PH_LITERAL: begin
				wr  = 1'b1;
				cmd = '{offset: cur_off[23:0], value: b, count: 8'd1, xr: xor_cfg, eof: 1'b0};
				step_rows(8'd1);
				lit_rem = lit_rem - 7'd1;
				if (lit_rem == 7'd0)
					op_done = 1'b1;
			end
			PH_RUNCOUNT: begin
				run_len  = b;
				parse_ph = PH_RUNVALUE;
			end
			default: begin
				if (run_len != 8'd0) begin
					wr  = 1'b1;
					cmd = '{offset: cur_off[23:0], value: b, count: run_len,
						xr: xor_cfg, eof: 1'b0};
					step_rows(run_len);
				end
				op_done = 1'b1;
			end
		endcase
		if (op_done) begin
			off_after = cur_off;
			eof       = close_op();
			if (eof) begin
				cur_off = '0;
				// A frame that ends without a write still gets a marker.
				if (!wr)
					pending_writes.push_back('{offset: off_after[23:0], value: 8'd0,
						count: 8'd0, xr: xor_cfg, eof: 1'b1});
			end
		end
		if (wr) begin
			cmd.eof = eof;
			pending_writes.push_back(cmd);
		end
	endfunction

	function automatic void report_mismatch(input string what, input write_cmd_t want,
			input write_cmd_t got);
		write_mismatches++;
		if (write_mismatches <= 10)
			$display({"%0t %s: expected off=%h val=%h cnt=%h xor=%b eof=%b,",
				" got off=%h val=%h cnt=%h xor=%b eof=%b"},
				$realtime, what, want.offset, want.value, want.count, want.xr, want.eof,
				got.offset, got.value, got.count, got.xr, got.eof);
	endfunction

	// Results are checked before the accepted byte is decoded, so both sides
	// of one edge are seen in a fixed order.
	always @(posedge clk) begin : scoreboard
		write_cmd_t got;
		write_cmd_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[23:0], m_tdata[31:24], m_tdata[39:32], m_tuser, m_tlast};
				if (pending_writes.size() == 0) begin
					report_mismatch("unexpected word", 'x, got);
				end else begin
					want = pending_writes.pop_front();
					if (got !== want)
						report_mismatch("wrong word", want, got);
				end
			end
			if (s_tvalid && s_tready)
				decode_delta_byte(s_tdata);
		end
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// Every task below starts and ends at a falling edge.
	task automatic send_delta(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		@(negedge clk);
	endtask

	// Holds the sender back until every predicted word has come out, then lets
	// the pipeline settle, since bytes without a result may still be inside.
	task automatic wait_for_idle();
		int n;
		n = 0;
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_writes.size() != 0 && n < DRAIN_LIMIT) begin
			@(negedge clk);
			n++;
		end
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] reg_idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'({reg_idx, 2'b00});
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (reg_idx)
			REG_ROW_STRIDE:   stride_cfg = value[15:0];
			REG_COLUMN_COUNT: cols_cfg   = value[15:0];
			REG_XOR_MODE:     xor_cfg    = value[0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input logic [15:0] stride, input logic [15:0] cols,
			input logic xr);
		wait_for_idle();
		write_reg(REG_ROW_STRIDE, {16'd0, stride});
		write_reg(REG_COLUMN_COUNT, {16'd0, cols});
		write_reg(REG_XOR_MODE, {31'd0, xr});
	endtask

	// One well-formed column with random operations of every kind.
	task automatic send_column(input int max_ops);
		int n_ops;
		int len;
		n_ops = $urandom_range(0, max_ops);
		send_delta(8'(n_ops));
		repeat (n_ops) begin
			case ($urandom_range(0, 9))
				0, 1, 2: send_delta(8'($urandom_range(1, 127)));
				3, 4, 5: begin
					len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 127)
						: $urandom_range(0, 6);
					send_delta(8'(128 + len));
					repeat (len) send_delta(8'($urandom_range(0, 255)));
				end
				default: begin
					send_delta(8'd0);
					if ($urandom_range(0, 9) == 0)
						send_delta(8'd0);
					else if ($urandom_range(0, 4) == 0)
						send_delta(8'($urandom_range(128, 255)));
					else
						send_delta(8'($urandom_range(1, 20)));
					send_delta(8'($urandom_range(0, 255)));
				end
			endcase
		end
	endtask

	task automatic send_frame();
		int cols;
		cols = (cols_cfg == 16'd0) ? 1 : int'(cols_cfg);
		repeat (cols) send_column(4);
	endtask

	// Steers the parser back to the start of a frame with the shortest bytes.
	task automatic realign_to_frame();
		while (!(parse_ph == PH_OPCOUNT && col_idx == 16'd0)) begin
			case (parse_ph)
				PH_OPCOUNT: send_delta(8'd0);
				PH_OP:      send_delta(8'd1);
				default:    send_delta(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	task automatic test_reset_config();
		// Registers as they come out of reset: a forty column frame.
		send_frame();
	endtask

	task automatic test_directed_ops();
		// Widest stride: three full skips wrap the offset, then a literal of
		// 0xff and a run of 255, which wraps again and ends the frame.
		configure(16'hffff, 16'd1, 1'b0);
		send_delta(8'd5);
		send_delta(8'd127);
		send_delta(8'd127);
		send_delta(8'd127);
		send_delta(8'd129);
		send_delta(8'hff);
		send_delta(8'd0);
		send_delta(8'd255);
		send_delta(8'ha5);
		// An empty column ends the frame with a marker.
		send_delta(8'd0);
		// An empty literal op ends the frame with a marker after a skip.
		send_delta(8'd2);
		send_delta(8'd1);
		send_delta(8'd128);
		// A run of zero writes nothing, so it also ends with a marker.
		send_delta(8'd1);
		send_delta(8'd0);
		send_delta(8'd0);
		send_delta(8'h5a);
		// A skip as the last operation.
		send_delta(8'd1);
		send_delta(8'd1);
		// Column count of zero acts as one column; literal of two bytes.
		configure(16'd1, 16'd0, 1'b1);
		send_delta(8'd1);
		send_delta(8'd130);
		send_delta(8'h00);
		send_delta(8'h80);
	endtask

	task automatic test_midframe_column_count();
		// Columns past the new count are treated as the last one.
		configure(16'd7, 16'hffff, 1'b1);
		repeat (3) send_column(1);
		configure(16'd7, 16'd2, 1'b0);
		send_column(1);
		realign_to_frame();
	endtask

	task automatic test_random_frames(input int target, input logic [15:0] stride,
			input logic [15:0] cols, input logic xr, input bit pause_midway);
		int  start;
		bit  paused;
		paused = 1'b0;
		configure(stride, cols, xr);
		start = words_sent;
		while (words_sent - start < target) begin
			send_frame();
			if (pause_midway && !paused && words_sent - start >= target / 2) begin
				wait_for_idle();
				paused = 1'b1;
			end
		end
	endtask

	task automatic test_noise_stream(input int n);
		configure(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 4)),
			1'($urandom_range(0, 1)));
		repeat (n) send_delta(8'($urandom_range(0, 255)));
		realign_to_frame();
	endtask

	initial begin
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		stride_cfg = RST_ROW_STRIDE;
		cols_cfg   = RST_COLUMN_COUNT;
		xor_cfg    = RST_XOR_MODE;
		parse_ph   = PH_OPCOUNT;
		col_idx    = '0;
		ops_rem    = '0;
		lit_rem    = '0;
		run_len    = '0;
		cur_off    = '0;
		send_idle_pct = 19;
		recv_idle_pct = 60;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_config();
		test_directed_ops();
		test_midframe_column_count();
		test_random_frames(250, 16'($urandom_range(2, 65534)), 16'd3, 1'b1, 1'b1);
		test_noise_stream(80);
		test_random_frames(200, 16'd1, 16'd1, 1'b0, 1'b0);

		send_idle_pct = 60;
		recv_idle_pct = 19;
		test_random_frames(250, 16'hffff, 16'd5, 1'b1, 1'b0);
		test_noise_stream(70);
		test_random_frames(200, 16'($urandom_range(1, 65535)), 16'd2, 1'b0, 1'b0);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_frames(220, 16'($urandom_range(1, 65535)),
			16'($urandom_range(1, 8)), 1'b1, 1'b1);

		wait_for_idle();
		if (pending_writes.size() != 0) begin
			$display("%0d expected words never arrived", pending_writes.size());
			write_mismatches += pending_writes.size();
		end
		if (write_mismatches == 0)
			$display("** vertical_byte_delta_decoder_core: PASSED **");
		else
			$display("** vertical_byte_delta_decoder_core: FAILED **");
		$finish;
	end

	initial begin
		#4000000;
		$display("timeout");
		$display("** vertical_byte_delta_decoder_core: FAILED **");
		$finish;
	end

endmodule

// File: sim.f
design/vbdd_pkg.sv
design/vbdd_cfg.sv
design/vbdd_parse.sv
design/vertical_byte_delta_decoder_core.sv
sim/tb_vertical_byte_delta_decoder_core.sv
